// ----- rtl/core/dcs_pkg.sv -----
// ---------------------------------------------------------------------------
// dcs_pkg
// Types and codes shared by the dispense cycle sequencer modules.
// ---------------------------------------------------------------------------
package dcs_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PEDAL     = 3'd0,
        OP_MOVE_DONE = 3'd1,
        OP_TICK      = 3'd2,
        OP_STOP      = 3'd3,
        OP_RESET     = 3'd4
    } t_op;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_REVERSE = 3'd2,
        CMD_SWIPE   = 3'd3,
        CMD_PAUSE   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STOP    = 3'd0,
        ST_FIRST   = 3'd1,
        ST_FORWARD = 3'd2,
        ST_REVERSE = 3'd3,
        ST_PAUSE   = 3'd4,
        ST_SWIPE   = 3'd5
    } t_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED         = 3'd0,
        CFG_SPEED_VALUE     = 3'd1,
        CFG_FIRST_AMOUNT    = 3'd2,
        CFG_PORTION_AMOUNT  = 3'd3,
        CFG_REVERSE_AMOUNT  = 3'd4,
        CFG_SWIPE_PULSE     = 3'd5,
        CFG_PAUSE_TICKS     = 3'd6,
        CFG_TARGET_PORTIONS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic              enabled;
        logic [DATA_W-1:0] speed_value;
        logic [DATA_W-1:0] first_amount;
        logic [DATA_W-1:0] portion_amount;
        logic [DATA_W-1:0] reverse_amount;
        logic [DATA_W-1:0] swipe_pulse;
        logic [DATA_W-1:0] pause_ticks;
        logic [DATA_W-1:0] target_portions;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] amount;
        logic              set_speed;
        logic              cycle_done;
        logic [DATA_W-1:0] portions_done;
    } t_result;

endpackage

// ----- rtl/core/dispense_cycle_sequencer.sv -----
// ---------------------------------------------------------------------------
// dispense_cycle_sequencer
// Pedal-driven dispensing sequencer: one event in, one result out.
// ---------------------------------------------------------------------------
// Pipeline: from input transaction to result valid through the input register,
//           then the result register.
// Throughput: one event per cycle while not stalled; the event logic is a single pass.
// Reset: synchronous, active low; clears state, config and both stage valid flags.
// ---------------------------------------------------------------------------
module dispense_cycle_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dcs_pkg::OP_W-1:0]         i_op,
    input  logic                             i_pedal_level,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dcs_pkg::CMD_W-1:0]        o_command,
    output logic [dcs_pkg::DATA_W-1:0]       o_amount,
    output logic                             o_set_speed,
    output logic                             o_cycle_done,
    output logic [dcs_pkg::DATA_W-1:0]       o_portions_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcs_pkg::DATA_W-1:0]       i_cfg_data
);
    import dcs_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    logic            r_in_valid;
    logic [OP_W-1:0] r_op;
    logic            r_pedal_level;
    logic            r_out_valid;
    t_result         r_res;

    logic out_advance;
    logic fire;
    logic in_accept;

    assign out_advance = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_valid && !out_advance;
    assign o_cfg_ready = 1'b1;

    dcs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    dcs_step_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (r_op),
        .i_pedal_level (r_pedal_level),
        .i_cfg         (cfg),
        .o_result      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op          <= i_op;
            r_pedal_level <= i_pedal_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command       = r_res.command;
    assign o_amount        = r_res.amount;
    assign o_set_speed     = r_res.set_speed;
    assign o_cycle_done    = r_res.cycle_done;
    assign o_portions_done = r_res.portions_done;

endmodule

// ----- rtl/core/dcs_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// dcs_cfg_regs
// Configuration register file, written one register per transaction.
// ---------------------------------------------------------------------------
module dcs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [dcs_pkg::DATA_W-1:0]     i_wr_data,
    output dcs_pkg::t_cfg                  o_cfg
);
    import dcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_ENABLED:         r_cfg.enabled         <= i_wr_data[0];
                CFG_SPEED_VALUE:     r_cfg.speed_value     <= i_wr_data;
                CFG_FIRST_AMOUNT:    r_cfg.first_amount    <= i_wr_data;
                CFG_PORTION_AMOUNT:  r_cfg.portion_amount  <= i_wr_data;
                CFG_REVERSE_AMOUNT:  r_cfg.reverse_amount  <= i_wr_data;
                CFG_SWIPE_PULSE:     r_cfg.swipe_pulse     <= i_wr_data;
                CFG_PAUSE_TICKS:     r_cfg.pause_ticks     <= i_wr_data;
                CFG_TARGET_PORTIONS: r_cfg.target_portions <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/dcs_step_core.sv -----
// ---------------------------------------------------------------------------
// dcs_step_core
// Sequencer state and the single-pass event logic producing one result.
// ---------------------------------------------------------------------------
module dcs_step_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [dcs_pkg::OP_W-1:0]    i_op,
    input  logic                        i_pedal_level,
    input  dcs_pkg::t_cfg               i_cfg,
    output dcs_pkg::t_result            o_result
);
    import dcs_pkg::*;

    t_step             r_step, n_step;
    t_step             r_after_pause, n_after_pause;
    logic              r_first_pending, n_first_pending;
    logic              r_cycle_running, n_cycle_running;
    logic              r_paused, n_paused;
    logic              r_prev_pedal, n_prev_pedal;
    logic [DATA_W-1:0] r_portion_count, n_portion_count;
    logic [DATA_W-1:0] r_pause_remaining, n_pause_remaining;
    logic              r_pause_active, n_pause_active;

    t_step   step_sel;
    logic    do_run;
    t_result res;

    always_comb begin
        n_step            = r_step;
        n_after_pause     = r_after_pause;
        n_first_pending   = r_first_pending;
        n_cycle_running   = r_cycle_running;
        n_paused          = r_paused;
        n_prev_pedal      = r_prev_pedal;
        n_portion_count   = r_portion_count;
        n_pause_remaining = r_pause_remaining;
        n_pause_active    = r_pause_active;
        step_sel          = r_step;
        do_run            = 1'b0;
        res               = '0;

        case (t_op'(i_op))
            OP_PEDAL: begin
                if (i_cfg.enabled) begin
                    if (!i_pedal_level && r_prev_pedal) begin
                        do_run = 1'b1;
                        if (r_first_pending) begin
                            step_sel        = ST_FIRST;
                            n_first_pending = 1'b0;
                            n_cycle_running = 1'b1;
                            res.set_speed   = 1'b1;
                        end else if (r_paused) begin
                            step_sel        = ST_FORWARD;
                            n_cycle_running = 1'b1;
                            n_paused        = 1'b0;
                            res.set_speed   = 1'b1;
                        end else begin
                            n_cycle_running = 1'b0;
                            n_paused        = 1'b1;
                        end
                    end
                    n_prev_pedal = i_pedal_level;
                end
            end
            OP_MOVE_DONE: begin
                do_run = 1'b1;
            end
            OP_TICK: begin
                if (r_pause_active) begin
                    if (r_pause_remaining > DATA_W'(1)) begin
                        n_pause_remaining = r_pause_remaining - DATA_W'(1);
                    end else begin
                        n_pause_active    = 1'b0;
                        n_pause_remaining = '0;
                        step_sel          = r_after_pause;
                        do_run            = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                n_cycle_running = 1'b0;
            end
            OP_RESET: begin
                n_first_pending = 1'b1;
                n_cycle_running = 1'b0;
                n_portion_count = '0;
                res.cycle_done  = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_run) begin
            n_step = step_sel;
            case (step_sel)
                ST_FIRST: begin
                    res.command = CMD_FORWARD;
                    res.amount  = i_cfg.first_amount;
                    n_step      = ST_REVERSE;
                end
                ST_FORWARD: begin
                    res.command = CMD_FORWARD;
                    res.amount  = i_cfg.portion_amount;
                    n_step      = ST_REVERSE;
                end
                ST_REVERSE: begin
                    res.command   = CMD_REVERSE;
                    res.amount    = i_cfg.reverse_amount;
                    n_step        = ST_PAUSE;
                    n_after_pause = ST_SWIPE;
                end
                ST_PAUSE: begin
                    res.command       = CMD_PAUSE;
                    n_pause_remaining = i_cfg.pause_ticks;
                    n_pause_active    = 1'b1;
                end
                ST_SWIPE: begin
                    if (i_cfg.target_portions != '0
                        && i_cfg.target_portions == r_portion_count) begin
                        n_cycle_running = 1'b0;
                    end
                    n_step          = n_cycle_running ? ST_FORWARD : ST_STOP;
                    res.command     = CMD_SWIPE;
                    res.amount      = i_cfg.swipe_pulse;
                    n_portion_count = r_portion_count + DATA_W'(1);
                    res.cycle_done  = 1'b1;
                end
                default: begin
                end
            endcase
        end

        res.portions_done = n_portion_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step            <= ST_STOP;
            r_after_pause     <= ST_STOP;
            r_first_pending   <= 1'b1;
            r_cycle_running   <= 1'b0;
            r_paused          <= 1'b0;
            r_prev_pedal      <= 1'b0;
            r_portion_count   <= '0;
            r_pause_remaining <= '0;
            r_pause_active    <= 1'b0;
        end else if (i_fire) begin
            r_step            <= n_step;
            r_after_pause     <= n_after_pause;
            r_first_pending   <= n_first_pending;
            r_cycle_running   <= n_cycle_running;
            r_paused          <= n_paused;
            r_prev_pedal      <= n_prev_pedal;
            r_portion_count   <= n_portion_count;
            r_pause_remaining <= n_pause_remaining;
            r_pause_active    <= n_pause_active;
        end
    end

    assign o_result = res;

endmodule
